// File: design/poc_pkg.sv
// Shared types, constants and a helper function for the pattern occurrence counter.
`default_nettype none

package poc_pkg;

  localparam int PAT_BYTES  = 16;
  localparam int LEN_CFG_W  = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int COUNT_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_PATTERN_LEN  = 2'd2,
    CFG_FOLD_CASE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    byte_t text_byte;
    logic  end_of_string;
  } in_t;

  typedef struct packed {
    logic               match_here;
    logic [COUNT_W-1:0] match_count;
    logic               string_done;
  } out_t;

  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [LEN_CFG_W-1:0]      eff_len;
    logic                      fold;
  } match_cfg_t;

  function automatic byte_t fold_byte(byte_t c, logic en);
    byte_t r;
    r = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/poc_matcher.sv
// Parallel compare of the byte window against the configured pattern.
`default_nettype none

module poc_matcher #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic [MAX_PATTERN-1:0][7:0] window,
  input  wire poc_pkg::match_cfg_t         cfg,
  output logic                             hit
);
  import poc_pkg::*;

  always_comb begin
    logic [LEN_CFG_W-1:0] offs;
    byte_t                pbyte;
    hit   = 1'b1;
    offs  = '0;
    pbyte = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LEN_CFG_W'(k) < cfg.eff_len) begin
        offs  = cfg.eff_len - LEN_CFG_W'(k) - LEN_CFG_W'(1);
        pbyte = cfg.pattern[offs[LEN_CFG_W-2:0]];
        if (fold_byte(window[k], cfg.fold) != fold_byte(pbyte, cfg.fold)) begin
          hit = 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/pattern_occurrence_counter.sv
// Top level of the pattern occurrence counter with its configuration registers.
//
// The block counts non-overlapping occurrences of a pattern of 1 to 16 bytes in a
// byte stream. Each input transaction carries one text byte and an end-of-string
// flag; each produces exactly one output transaction with a match flag, the
// running saturating count and an echo of the end-of-string flag.
// The whole window compare is combinational between the state registers and the
// output register, so the result appears in the cycle after the input transaction;
// a new byte is taken while in_stall is low: throughput is one byte per cycle.
// The output register is the only buffer; in_stall is raised only while it holds
// a result and the receiver stalls, and a stalled result holds its value.
// The user must write configuration through cfg_we, cfg_index and cfg_wdata while
// the block is idle, which it does not enforce; new values apply to the next byte.
// Reset clears the window, the byte count, the overlap blocker and the count, and
// returns the pattern registers to zero, the length to one and case folding off.
// An end-of-string byte clears the same state after its result is produced.
`default_nettype none

module pattern_occurrence_counter #(
  parameter int MAX_PATTERN = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire poc_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output poc_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [poc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [poc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import poc_pkg::*;

  localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
  localparam int BLK_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_DATA_W-1:0] pat_low_r;
  logic [CFG_DATA_W-1:0] pat_high_r;
  logic [LEN_CFG_W-1:0]  pat_len_r;
  logic                  fold_r;

  logic [MAX_PATTERN-1:0][7:0] win_r;
  logic [MAX_PATTERN-1:0][7:0] win_nxt;
  logic [SEEN_W-1:0]           seen_r;
  logic [SEEN_W-1:0]           seen_nxt;
  logic [BLK_W-1:0]            blk_r;
  logic [BLK_W-1:0]            blk_nxt;
  logic [COUNT_W-1:0]          total_r;
  logic [COUNT_W-1:0]          total_nxt;

  logic                        out_valid_r;
  out_t                        out_data_r;

  logic                        accept;
  logic                        raw_hit;
  logic                        hit;
  match_cfg_t                  mcfg;

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= LEN_CFG_W'(1);
      fold_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH: pat_high_r <= cfg_wdata;
        CFG_PATTERN_LEN:  pat_len_r  <= cfg_wdata[LEN_CFG_W-1:0];
        CFG_FOLD_CASE:    fold_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mcfg.pattern = {pat_high_r, pat_low_r};
    mcfg.fold    = fold_r;
    priority if (pat_len_r == '0) begin
      mcfg.eff_len = LEN_CFG_W'(1);
    end else if (pat_len_r > LEN_CFG_W'(MAX_PATTERN)) begin
      mcfg.eff_len = LEN_CFG_W'(MAX_PATTERN);
    end else begin
      mcfg.eff_len = pat_len_r;
    end
  end

  always_comb begin
    win_nxt[0] = in_data.text_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_nxt[k] = win_r[k-1];
    end
    seen_nxt = (seen_r < SEEN_W'(MAX_PATTERN)) ? seen_r + SEEN_W'(1) : seen_r;
  end

  poc_matcher #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_matcher (
    .window (win_nxt),
    .cfg    (mcfg),
    .hit    (raw_hit)
  );

  always_comb begin
    hit = raw_hit && (blk_r == '0) && (LEN_CFG_W'(seen_nxt) >= mcfg.eff_len);
    if (hit) begin
      blk_nxt = BLK_W'(mcfg.eff_len - LEN_CFG_W'(1));
    end else if (blk_r != '0) begin
      blk_nxt = blk_r - BLK_W'(1);
    end else begin
      blk_nxt = blk_r;
    end
    total_nxt = (hit && (total_r != COUNT_MAX)) ? total_r + COUNT_W'(1) : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      seen_r      <= '0;
      blk_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_data.end_of_string) begin
          win_r   <= '0;
          seen_r  <= '0;
          blk_r   <= '0;
          total_r <= '0;
        end else begin
          win_r   <= win_nxt;
          seen_r  <= seen_nxt;
          blk_r   <= blk_nxt;
          total_r <= total_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.match_here  <= hit;
      out_data_r.match_count <= total_nxt;
      out_data_r.string_done <= in_data.end_of_string;
    end
  end

  // A byte taken while the blocker is active never reports a match.
  a_blocked_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (blk_r != '0)) |=> !out_data_r.match_here)
    else $error("match reported while overlap blocker active");

  // The end of a string leaves the count and byte tally cleared.
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.end_of_string) |=> ((total_r == '0) && (seen_r == '0)))
    else $error("state not cleared after end of string");

  // A reported match always comes with a nonzero count.
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.match_here) |-> (out_data_r.match_count != '0))
    else $error("match reported with zero count");

endmodule

`default_nettype wire
